[design/mpf_pkg.sv]
// Package for the page-organized monochrome frame buffer.
// Holds the controller state type, item kind and draw op codes, and refresh command bytes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mpf_pkg;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE
    } state_t;

    // Item kinds
    localparam logic [1:0] KIND_DRAW    = 2'd0;
    localparam logic [1:0] KIND_LOAD    = 2'd1;
    localparam logic [1:0] KIND_REFRESH = 2'd2;

    // Pixel draw operations
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_TOGGLE = 2'd3;

    // Refresh command bytes sent ahead of each page
    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

    // Positions within one page of the refresh stream
    localparam int STEP_PAGE_SEL = 0;
    localparam int STEP_COL_LOW  = 1;
    localparam int STEP_COL_HIGH = 2;
    localparam int CMD_STEPS     = 3;

endpackage

`default_nettype wire

[design/mpf_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[design/mono_page_framebuffer.sv]
// Timing: a refresh tick gives its result in the cycle after the transaction; a load
// is written when accepted; a draw reads, then writes back, with busy high during write back.
// Throughput: one load or refresh tick per cycle while busy is low; a draw holds off the
// next item during its write back through the frame store's single read-modify-write path.
// Reset: asynchronous; a clearing pass then zeroes all PANEL_WIDTH * ceil(PANEL_HEIGHT/8)
// store bytes (512 by default) with busy high. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module mono_page_framebuffer
    import mpf_pkg::*;
#(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] kind,
    input  wire logic [7:0] pixel_x,
    input  wire logic [7:0] pixel_y,
    input  wire logic [1:0] draw_op,
    input  wire logic [8:0] image_index,
    input  wire logic [7:0] image_byte,
    output logic            result_strobe,
    output logic [7:0]      out_byte,
    output logic            is_command,
    output logic            frame_done
);

    localparam int PAGES      = (PANEL_HEIGHT + 7) / 8;
    localparam int STORE_SIZE = PANEL_WIDTH * PAGES;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int PAGE_W     = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int STEP_W     = $clog2(PANEL_WIDTH + CMD_STEPS);

    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(STORE_SIZE - 1);
    localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGES - 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(PANEL_WIDTH + CMD_STEPS - 1);

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] clear_addr_reg, clear_addr_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [ADDR_W-1:0] data_addr_reg, data_addr_next;

    logic [ADDR_W-1:0] wb_addr_reg;
    logic [1:0]        wb_op_reg;
    logic [2:0]        wb_bit_reg;

    logic       strobe_reg, strobe_next;
    logic       cmd_reg, cmd_next;
    logic       done_reg, done_next;
    logic [7:0] cmd_byte_reg, cmd_byte_next;

    logic              accept;
    logic              draw_hit;
    logic              load_hit;
    logic              refresh_hit;
    logic [ADDR_W-1:0] draw_addr;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [7:0]        ram_wr_data;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [7:0]        ram_rd_data;
    logic [7:0]        bit_mask;
    logic [7:0]        modified_byte;

    // Decode the incoming transaction
    assign busy        = (state_reg != ST_IDLE);
    assign accept      = start && !busy;
    assign draw_hit    = accept && (kind == KIND_DRAW) && (draw_op != OP_NONE)
                         && (32'(pixel_x) < 32'(PANEL_WIDTH))
                         && (32'(pixel_y) < 32'(PANEL_HEIGHT));
    assign load_hit    = accept && (kind == KIND_LOAD)
                         && (32'(image_index) < 32'(STORE_SIZE));
    assign refresh_hit = accept && (kind == KIND_REFRESH);
    assign draw_addr   = ADDR_W'(32'(pixel_x) + 32'(pixel_y[7:3]) * 32'(PANEL_WIDTH));

    // Apply the draw op to the byte read back from the store
    assign bit_mask = 8'(1) << wb_bit_reg;

    always_comb
    begin
        case (wb_op_reg)
            OP_SET:    modified_byte = ram_rd_data | bit_mask;
            OP_CLEAR:  modified_byte = ram_rd_data & ~bit_mask;
            OP_TOGGLE: modified_byte = ram_rd_data ^ bit_mask;
            default:   modified_byte = ram_rd_data;
        endcase
    end

    // Select the store write source: clearing pass, write back, or image load
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = ADDR_W'(image_index);
        ram_wr_data = image_byte;
        if (state_reg == ST_CLEAR)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clear_addr_reg;
            ram_wr_data = 8'h00;
        end
        else if (state_reg == ST_WRITE)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = wb_addr_reg;
            ram_wr_data = modified_byte;
        end
        else if (load_hit)
        begin
            ram_wr_en = 1'b1;
        end
    end

    // Read the pixel byte for a draw, else the next refresh data byte
    assign ram_rd_addr = draw_hit ? draw_addr : data_addr_reg;

    mpf_ram #(
        .WIDTH (8),
        .DEPTH (STORE_SIZE)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_addr_reg == ADDR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (draw_hit)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Clearing counter and refresh position
    always_comb
    begin
        clear_addr_next = clear_addr_reg;
        page_next       = page_reg;
        step_next       = step_reg;
        data_addr_next  = data_addr_reg;
        if (state_reg == ST_CLEAR)
        begin
            clear_addr_next = clear_addr_reg + ADDR_W'(1);
        end
        if (refresh_hit)
        begin
            if (32'(step_reg) >= CMD_STEPS)
            begin
                data_addr_next = data_addr_reg + ADDR_W'(1);
            end
            if (step_reg == STEP_LAST)
            begin
                step_next = '0;
                if (page_reg == PAGE_LAST)
                begin
                    page_next      = '0;
                    data_addr_next = '0;
                end
                else
                begin
                    page_next = page_reg + PAGE_W'(1);
                end
            end
            else
            begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    // Result fields for a refresh tick
    always_comb
    begin
        strobe_next   = refresh_hit;
        cmd_next      = 1'b0;
        done_next     = 1'b0;
        cmd_byte_next = CMD_COL_LOW;
        if (refresh_hit)
        begin
            if (step_reg == STEP_W'(STEP_PAGE_SEL))
            begin
                cmd_next      = 1'b1;
                cmd_byte_next = CMD_PAGE_BASE + 8'(page_reg);
            end
            else if (step_reg == STEP_W'(STEP_COL_LOW))
            begin
                cmd_next      = 1'b1;
                cmd_byte_next = CMD_COL_LOW;
            end
            else if (step_reg == STEP_W'(STEP_COL_HIGH))
            begin
                cmd_next      = 1'b1;
                cmd_byte_next = CMD_COL_HIGH;
            end
            done_next = (step_reg == STEP_LAST) && (page_reg == PAGE_LAST);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clear_addr_reg <= '0;
            page_reg       <= '0;
            step_reg       <= '0;
            data_addr_reg  <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
            page_reg       <= page_next;
            step_reg       <= step_next;
            data_addr_reg  <= data_addr_next;
            strobe_reg     <= strobe_next;
        end
    end

    // Payload registers: hold the draw for write back and the result fields
    always_ff @(posedge clk)
    begin
        if (draw_hit)
        begin
            wb_addr_reg <= draw_addr;
            wb_op_reg   <= draw_op;
            wb_bit_reg  <= pixel_y[2:0];
        end
        cmd_reg      <= cmd_next;
        done_reg     <= done_next;
        cmd_byte_reg <= cmd_byte_next;
    end

    assign result_strobe = strobe_reg;
    assign is_command    = cmd_reg;
    assign frame_done    = done_reg;
    assign out_byte      = cmd_reg ? cmd_byte_reg : ram_rd_data;

`ifndef NO_ASSERTIONS
    // A result appears only in the cycle after a refresh transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(start && !busy && (kind == KIND_REFRESH)))
        else $error("result without a refresh transaction");

    // Write back is always followed by idle in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |=> (state_reg == ST_IDLE))
        else $error("write back did not return to idle");

    // End of frame is flagged on a data byte only
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && done_reg) |-> !cmd_reg)
        else $error("frame end flagged on a command byte");

    // No transaction is taken during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> !strobe_reg)
        else $error("result during clearing pass");

    // The refresh data address wraps together with the frame position
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && done_reg) |-> (data_addr_reg == '0) && (page_reg == '0))
        else $error("refresh position did not wrap at frame end");
`endif

endmodule

`default_nettype wire

[bench/mono_page_framebuffer_tb.sv]
// Testbench for mono_page_framebuffer: directed table, then random draw/load/refresh/spare-kind traffic.
// Refresh results are checked against a shadow copy of the frame store and refresh position, or typed table rows.
// Depends on design/mpf_pkg.sv, design/mpf_ram.sv and design/mono_page_framebuffer.sv.
`timescale 1ns / 1ps

module mono_page_framebuffer_tb
    import mpf_pkg::*;
();

    localparam int PANEL_W        = 128;
    localparam int PANEL_H        = 32;
    localparam int PAGES          = (PANEL_H + 7) / 8;
    localparam int STORE_BYTES    = PANEL_W * PAGES;
    localparam int RANDOM_ITEMS   = 1550;
    localparam int WATCHDOG_LIMIT = 3000;

    // Kind code that the block has no use for
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] x;
        logic [7:0] y;
        logic [1:0] op;
        logic [8:0] idx;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       cmd;
        logic       done;
    } result_t;

    typedef struct packed {
        item_t   it;
        logic    typed;
        result_t res;
    } row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic [1:0] kind = '0;
    logic [7:0] pixel_x = '0;
    logic [7:0] pixel_y = '0;
    logic [1:0] draw_op = '0;
    logic [8:0] image_index = '0;
    logic [7:0] image_byte = '0;
    logic       busy;
    logic       result_strobe;
    logic [7:0] out_byte;
    logic       is_command;
    logic       frame_done;

    // Shadow of the block state
    logic [7:0] shadow_px [STORE_BYTES];
    int         shadow_page;
    int         shadow_step;

    result_t     refresh_due [$];
    result_t     head_res;
    row_t        directed [$];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;

    mono_page_framebuffer #(
        .PANEL_WIDTH  (PANEL_W),
        .PANEL_HEIGHT (PANEL_H)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .draw_op       (draw_op),
        .image_index   (image_index),
        .image_byte    (image_byte),
        .result_strobe (result_strobe),
        .out_byte      (out_byte),
        .is_command    (is_command),
        .frame_done    (frame_done)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Apply one transaction to the shadow state; return the refresh byte it emits, if any
    function automatic void panel_apply(input item_t it, output bit emit, output result_t res);
        int         addr;
        logic [7:0] mask;
        emit = 1'b0;
        res  = '0;
        case (it.kind)
            KIND_DRAW:
            begin
                if (it.x < PANEL_W && it.y < PANEL_H)
                begin
                    addr = it.x + (it.y >> 3) * PANEL_W;
                    mask = 8'h01 << it.y[2:0];
                    case (it.op)
                        OP_SET:    shadow_px[addr] = shadow_px[addr] | mask;
                        OP_CLEAR:  shadow_px[addr] = shadow_px[addr] & ~mask;
                        OP_TOGGLE: shadow_px[addr] = shadow_px[addr] ^ mask;
                        default:   ;
                    endcase
                end
            end
            KIND_LOAD:
            begin
                if (it.idx < STORE_BYTES)
                    shadow_px[it.idx] = it.data;
            end
            KIND_REFRESH:
            begin
                emit = 1'b1;
                if (shadow_step < CMD_STEPS)
                begin
                    res.cmd = 1'b1;
                    case (shadow_step)
                        STEP_PAGE_SEL: res.data = CMD_PAGE_BASE + 8'(shadow_page);
                        STEP_COL_LOW:  res.data = CMD_COL_LOW;
                        default:       res.data = CMD_COL_HIGH;
                    endcase
                end
                else
                begin
                    res.data = shadow_px[shadow_step - CMD_STEPS + shadow_page * PANEL_W];
                end
                // Advance the position, wrapping at page and frame ends
                shadow_step++;
                if (shadow_step >= CMD_STEPS + PANEL_W)
                begin
                    shadow_step = 0;
                    shadow_page++;
                    if (shadow_page >= PAGES)
                    begin
                        shadow_page = 0;
                        res.done = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic row_t mk_row(input logic [1:0] k, input logic [7:0] x, input logic [7:0] y,
                                    input logic [1:0] op, input logic [8:0] idx,
                                    input logic [7:0] data, input logic typed,
                                    input logic [7:0] rb, input logic rc, input logic rd);
        row_t r;
        r.it    = '{kind: k, x: x, y: y, op: op, idx: idx, data: data};
        r.typed = typed;
        r.res   = '{data: rb, cmd: rc, done: rd};
        return r;
    endfunction

    function automatic item_t random_item();
        item_t it;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 25)
            it.kind = KIND_DRAW;
        else if (pick < 40)
            it.kind = KIND_LOAD;
        else if (pick < 95)
            it.kind = KIND_REFRESH;
        else
            it.kind = KIND_SPARE;
        // Keep most draws on the panel
        it.x    = ($urandom_range(99) < 80) ? 8'($urandom_range(PANEL_W - 1))
                                            : 8'($urandom_range(255));
        it.y    = ($urandom_range(99) < 80) ? 8'($urandom_range(PANEL_H - 1))
                                            : 8'($urandom_range(255));
        it.op   = 2'($urandom_range(3));
        it.idx  = 9'($urandom_range(511));
        it.data = 8'($urandom_range(255));
        return it;
    endfunction

    // Drive one transaction, hold it until accepted, then record what it should emit
    task automatic send_item(input item_t it, input logic typed, input result_t typed_res,
                             input bit may_idle);
        bit      emit;
        result_t res;
        // Idle the sender at random while may_idle is set
        while (may_idle && $urandom_range(99) < 21)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        kind        <= it.kind;
        pixel_x     <= it.x;
        pixel_y     <= it.y;
        draw_op     <= it.op;
        image_index <= it.idx;
        image_byte  <= it.data;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        panel_apply(it, emit, res);
        if (emit)
            refresh_due.push_back(typed ? typed_res : res);
    endtask

    // Hold off the sender until every pending refresh byte has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (refresh_due.size() != 0)
            @(posedge clk);
    endtask

    // Compare each strobed result with the oldest pending one
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (refresh_due.size() == 0)
            begin
                $error("unexpected result: out_byte %h is_command %b frame_done %b",
                       out_byte, is_command, frame_done);
                mismatch_count++;
            end
            else
            begin
                head_res = refresh_due.pop_front();
                if (out_byte !== head_res.data)
                begin
                    $error("out_byte: expected %h, got %h", head_res.data, out_byte);
                    mismatch_count++;
                end
                if (is_command !== head_res.cmd)
                begin
                    $error("is_command: expected %b, got %b", head_res.cmd, is_command);
                    mismatch_count++;
                end
                if (frame_done !== head_res.done)
                begin
                    $error("frame_done: expected %b, got %b", head_res.done, frame_done);
                    mismatch_count++;
                end
            end
        end
    end

    // Stop a hung run: count cycles without an accepted transaction
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        item_t       it;
        int unsigned n;
        for (int i = 0; i < STORE_BYTES; i++)
            shadow_px[i] = 8'h00;
        shadow_page = 0;
        shadow_step = 0;

        // Directed rows: command bytes after reset, extremes, off-panel draws, spare kind
        directed.push_back(mk_row(KIND_REFRESH, 0, 0, OP_NONE, 0, 0, 1, CMD_PAGE_BASE, 1, 0));
        directed.push_back(mk_row(KIND_REFRESH, 0, 0, OP_NONE, 0, 0, 1, CMD_COL_LOW, 1, 0));
        directed.push_back(mk_row(KIND_REFRESH, 0, 0, OP_NONE, 0, 0, 1, CMD_COL_HIGH, 1, 0));
        directed.push_back(mk_row(KIND_REFRESH, 0, 0, OP_NONE, 0, 0, 1, 8'h00, 0, 0));
        directed.push_back(mk_row(KIND_LOAD, 0, 0, OP_NONE, 9'd0, 8'hFF, 0, 0, 0, 0));
        directed.push_back(mk_row(KIND_LOAD, 0, 0, OP_NONE, 9'd511, 8'hA5, 0, 0, 0, 0));
        directed.push_back(mk_row(KIND_LOAD, 0, 0, OP_NONE, 9'd170, 8'h5A, 0, 0, 0, 0));
        directed.push_back(mk_row(KIND_DRAW, 8'd1, 8'd0, OP_SET, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(KIND_DRAW, 8'd1, 8'd7, OP_TOGGLE, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(KIND_DRAW, 8'd127, 8'd31, OP_SET, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(KIND_DRAW, 8'd128, 8'd0, OP_SET, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(KIND_DRAW, 8'd255, 8'd255, OP_TOGGLE, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(KIND_DRAW, 8'd0, 8'd32, OP_SET, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(KIND_DRAW, 8'd0, 8'd0, OP_CLEAR, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(KIND_DRAW, 8'd2, 8'd3, OP_NONE, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(KIND_SPARE, 8'hFF, 8'hFF, OP_TOGGLE, 9'h1FF, 8'hFF,
                                  0, 0, 0, 0));
        directed.push_back(mk_row(KIND_REFRESH, 0, 0, OP_NONE, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(KIND_REFRESH, 0, 0, OP_NONE, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(KIND_REFRESH, 0, 0, OP_NONE, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(KIND_DRAW, 8'd1, 8'd7, OP_TOGGLE, 0, 0, 0, 0, 0, 0));

        // Hold reset, then release it on a clock edge
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_item(directed[i].it, directed[i].typed, directed[i].res, 1'b1);
        drain_results();

        // Random traffic; a quiet stretch with no idling in the middle
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            it = random_item();
            if (n == 1000)
                drain_results();
            send_item(it, 1'b0, '0, !(n >= 500 && n < 900));
            n++;
        end

        // Let the last results and any draw in flight finish
        start <= 1'b0;
        @(posedge clk);
        while (refresh_due.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[mono_page_framebuffer.f]
design/mpf_pkg.sv
design/mpf_ram.sv
design/mono_page_framebuffer.sv
bench/mono_page_framebuffer_tb.sv
